### rtl/core/assert_macros.svh
// Assertion macros shared by the warp core RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ABWN_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("abwn assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ABWN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abwn assertion failed");

`endif

### rtl/core/abwn_pkg.sv
// Shared types and constants of the affine bilinear warp core.
// No dependencies; imported by every module of the core except abwn_ram.
package abwn_pkg;

   localparam int QUEUE_DEPTH  = 8;
   localparam int QCOUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS     = QCOUNT_BITS + 1;
   localparam int DIM_BITS     = 13;
   localparam int CSR_IDX_BITS = 3;
   localparam int PIX_BITS     = 24;
   localparam logic [7:0] PAD_VALUE = 8'd114;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WARP = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COEF_A     = 3'd0,
      CSR_COEF_B     = 3'd1,
      CSR_COEF_C     = 3'd2,
      CSR_COEF_D     = 3'd3,
      CSR_COEF_E     = 3'd4,
      CSR_COEF_F     = 3'd5,
      CSR_SRC_WIDTH  = 3'd6,
      CSR_SRC_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic       operation;
      logic [9:0] col;
      logic [9:0] row;
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] red_norm;
      logic [16:0] green_norm;
      logic [16:0] blue_norm;
      logic [9:0]  out_col;
      logic [9:0]  out_row;
   } rsp_payload_type;

endpackage

### rtl/core/affine_bilinear_warp_normalize_core.sv
// Channel    | Direction | Handshake          | Payload
// req        | in        | req_valid/stall    | load or warp request
// rsp        | out       | rsp_valid/stall    | normalized RGB plus destination col/row
// csr        | in        | csr_wr_en          | index + 32-bit write data
//
// One request per cycle sustained while the credit check does not stall requests; a warp result
// passes through the front stages (capture, multiply, sum, bounds, bank read), the queue and a 3-stage blend.
// Four parity-interleaved frame banks give all four neighbours in one read.
// Reset is synchronous; the frame store is not cleared and holds garbage until loaded.
// A stalled result port backs up the 8-entry queue; the front stalls requests by credit.
// Depends on abwn_pkg, abwn_front, abwn_queue, abwn_back and assert_macros.svh.
module affine_bilinear_warp_normalize_core #(
   parameter int SRC_MAX_W = 1024,
   parameter int SRC_MAX_H = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  abwn_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output abwn_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [abwn_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);
   import abwn_pkg::*;
   `include "assert_macros.svh"

   localparam int ENTRY_W = 4 * PIX_BITS + 2 * FRAC_BITS + 20;

   logic                   q_push, q_pop, q_not_empty, q_full;
   logic [ENTRY_W-1:0]     q_in, q_head;
   logic [QCOUNT_BITS-1:0] q_count;

   abwn_front #(
      .SRC_MAX_W (SRC_MAX_W),
      .SRC_MAX_H (SRC_MAX_H),
      .FRAC_BITS (FRAC_BITS),
      .ENTRY_W   (ENTRY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   abwn_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head_data (q_head),
      .not_empty (q_not_empty),
      .full      (q_full),
      .count     (q_count)
   );

   abwn_back #(
      .FRAC_BITS (FRAC_BITS),
      .ENTRY_W   (ENTRY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `ABWN_ASSERT_NOW(a_no_overflow, q_push && !q_pop, !q_full)
   `ABWN_ASSERT_NOW(a_no_underflow, q_pop, q_not_empty)
   `ABWN_ASSERT_NOW(a_full_stalls, q_full, req_stall)
   `ABWN_ASSERT_NEXT(a_stalled_rsp_holds_queue, rsp_valid && rsp_stall, !$past(q_pop))
endmodule

### rtl/core/abwn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module abwn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/abwn_queue.sv
// Short flop queue between the front and back halves of the warp core.
// Depends on abwn_pkg for the count width.
module abwn_queue #(
   parameter int WIDTH = 168
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [WIDTH-1:0]                   push_data,
   input  logic                               pop,
   output logic [WIDTH-1:0]                   head_data,
   output logic                               not_empty,
   output logic                               full,
   output logic [abwn_pkg::QCOUNT_BITS-1:0]   count
);
   import abwn_pkg::*;
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]       slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign count     = count_ff;
endmodule

### rtl/core/abwn_front.sv
// Front half: registers, affine mapping, neighbour bounds, banked frame store.
// Depends on abwn_pkg and abwn_ram; feeds abwn_queue with fetched neighbours.
module abwn_front #(
   parameter int SRC_MAX_W = 1024,
   parameter int SRC_MAX_H = 1024,
   parameter int FRAC_BITS = 16,
   parameter int ENTRY_W   = 4 * 24 + 2 * 16 + 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  abwn_pkg::req_payload_type             req_payload,
   input  logic                                  csr_wr_en,
   input  logic [abwn_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [31:0]                           csr_wdata,
   input  logic [abwn_pkg::QCOUNT_BITS-1:0]      q_count,
   output logic                                  q_push,
   output logic [ENTRY_W-1:0]                    q_data
);
   import abwn_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int PW     = 43;
   localparam int SW     = 45;
   localparam int IW     = SW - F;
   localparam int XB     = $clog2(SRC_MAX_W) + 1;
   localparam int YB     = $clog2(SRC_MAX_H) + 1;
   localparam int HALF_W = (SRC_MAX_W + 1) / 2;
   localparam int HALF_H = (SRC_MAX_H + 1) / 2;
   localparam int BANK_D = HALF_W * HALF_H;
   localparam int AW     = $clog2(BANK_D);
   localparam int RAM_D  = 1 << AW;

   // configuration registers
   logic signed [31:0] coef_ff [6];
   logic [10:0]        width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= 32'sd65536;
         coef_ff[1] <= '0;
         coef_ff[2] <= '0;
         coef_ff[3] <= '0;
         coef_ff[4] <= 32'sd65536;
         coef_ff[5] <= '0;
         width_ff   <= 11'd1024;
         height_ff  <= 11'd1024;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_A:     coef_ff[0] <= csr_wdata;
            CSR_COEF_B:     coef_ff[1] <= csr_wdata;
            CSR_COEF_C:     coef_ff[2] <= csr_wdata;
            CSR_COEF_D:     coef_ff[3] <= csr_wdata;
            CSR_COEF_E:     coef_ff[4] <= csr_wdata;
            CSR_COEF_F:     coef_ff[5] <= csr_wdata;
            CSR_SRC_WIDTH:  width_ff   <= csr_wdata[10:0];
            CSR_SRC_HEIGHT: height_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   logic [DIM_BITS-1:0] w_eff, h_eff;
   assign w_eff = (32'(width_ff) > SRC_MAX_W) ? DIM_BITS'(SRC_MAX_W) : DIM_BITS'(width_ff);
   assign h_eff = (32'(height_ff) > SRC_MAX_H) ? DIM_BITS'(SRC_MAX_H) : DIM_BITS'(height_ff);

   // credit: every warp in flight owns a queue slot
   logic                accept;
   logic [OCC_BITS-1:0] occupancy;
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic                s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff;

   assign occupancy = OCC_BITS'(q_count)
                    + OCC_BITS'(s1_valid_ff & (s1_op_ff == OP_WARP))
                    + OCC_BITS'(s2_valid_ff & (s2_op_ff == OP_WARP))
                    + OCC_BITS'(s3_valid_ff & (s3_op_ff == OP_WARP))
                    + OCC_BITS'(s4_valid_ff & (s4_op_ff == OP_WARP))
                    + OCC_BITS'(s5_valid_ff);
   assign req_stall = (occupancy >= OCC_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid & ~req_stall;

   // stage 1: capture request
   logic [9:0]  s1_col_ff, s1_row_ff;
   logic [23:0] s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_op_ff  <= req_payload.operation;
         s1_col_ff <= req_payload.col;
         s1_row_ff <= req_payload.row;
         s1_pix_ff <= {req_payload.red_in, req_payload.green_in, req_payload.blue_in};
      end
   end

   // stage 2: matrix products
   logic signed [10:0]  col_s, row_s;
   logic signed [PW-1:0] pa_ff, pb_ff, pd_ff, pe_ff;
   logic [9:0]  s2_col_ff, s2_row_ff;
   logic [23:0] s2_pix_ff;

   assign col_s = $signed({1'b0, s1_col_ff});
   assign row_s = $signed({1'b0, s1_row_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      pa_ff     <= PW'(coef_ff[0] * col_s);
      pb_ff     <= PW'(coef_ff[1] * row_s);
      pd_ff     <= PW'(coef_ff[3] * col_s);
      pe_ff     <= PW'(coef_ff[4] * row_s);
      s2_op_ff  <= s1_op_ff;
      s2_col_ff <= s1_col_ff;
      s2_row_ff <= s1_row_ff;
      s2_pix_ff <= s1_pix_ff;
   end

   // stage 3: source position
   logic signed [SW-1:0] sx_ff, sy_ff;
   logic [9:0]  s3_col_ff, s3_row_ff;
   logic [23:0] s3_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      sx_ff     <= SW'(pa_ff) + SW'(pb_ff) + SW'(coef_ff[2]);
      sy_ff     <= SW'(pd_ff) + SW'(pe_ff) + SW'(coef_ff[5]);
      s3_op_ff  <= s2_op_ff;
      s3_col_ff <= s2_col_ff;
      s3_row_ff <= s2_row_ff;
      s3_pix_ff <= s2_pix_ff;
   end

   // stage 4: floor, fraction, neighbour bounds
   logic signed [IW-1:0] x0, y0;
   logic signed [IW:0]   x1, y1;
   logic vx0, vx1, vy0, vy1;

   always_comb begin
      x0  = sx_ff[SW-1:F];
      y0  = sy_ff[SW-1:F];
      x1  = (IW+1)'(x0) + (IW+1)'(1);
      y1  = (IW+1)'(y0) + (IW+1)'(1);
      vx0 = ~x0[IW-1] && (x0 < $signed(IW'(w_eff)));
      vx1 = ~x1[IW]   && (x1 < $signed((IW+1)'(w_eff)));
      vy0 = ~y0[IW-1] && (y0 < $signed(IW'(h_eff)));
      vy1 = ~y1[IW]   && (y1 < $signed((IW+1)'(h_eff)));
   end

   logic          s4_vx0_ff, s4_vx1_ff, s4_vy0_ff, s4_vy1_ff;
   logic          s4_xpar_ff, s4_ypar_ff;
   logic [XB-2:0] s4_xh0_ff, s4_xh1_ff;
   logic [YB-2:0] s4_yh0_ff, s4_yh1_ff;
   logic [F-1:0]  s4_fx_ff, s4_fy_ff;
   logic [9:0]    s4_col_ff, s4_row_ff;
   logic [23:0]   s4_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_vx0_ff  <= vx0;
      s4_vx1_ff  <= vx1;
      s4_vy0_ff  <= vy0;
      s4_vy1_ff  <= vy1;
      s4_xpar_ff <= x0[0];
      s4_ypar_ff <= y0[0];
      s4_xh0_ff  <= x0[XB-1:1];
      s4_xh1_ff  <= x1[XB-1:1];
      s4_yh0_ff  <= y0[YB-1:1];
      s4_yh1_ff  <= y1[YB-1:1];
      s4_fx_ff   <= sx_ff[F-1:0];
      s4_fy_ff   <= sy_ff[F-1:0];
      s4_op_ff   <= s3_op_ff;
      s4_col_ff  <= s3_col_ff;
      s4_row_ff  <= s3_row_ff;
      s4_pix_ff  <= s3_pix_ff;
   end

   // stage 4 -> 5: bank access; bank index is {y parity, x parity}
   logic          load_ok;
   logic [1:0]    load_bank;
   logic [AW-1:0] load_addr;
   logic [AW-1:0] rd_addr [4];
   logic          bank_ok [4];
   logic          wr_en   [4];
   logic          rd_en;
   logic [23:0]   rd_data [4];

   always_comb begin
      load_ok   = s4_valid_ff && (s4_op_ff == OP_LOAD)
               && (32'(s4_col_ff) < SRC_MAX_W) && (32'(s4_row_ff) < SRC_MAX_H);
      load_bank = {s4_row_ff[0], s4_col_ff[0]};
      load_addr = AW'(s4_row_ff[9:1]) * AW'(HALF_W) + AW'(s4_col_ff[9:1]);
      rd_en     = s4_valid_ff && (s4_op_ff == OP_WARP);
      for (int b = 0; b < 4; b++) begin
         logic          use_x0, use_y0;
         logic [XB-2:0] xh;
         logic [YB-2:0] yh;
         use_x0     = (b[0] == s4_xpar_ff);
         use_y0     = (b[1] == s4_ypar_ff);
         xh         = use_x0 ? s4_xh0_ff : s4_xh1_ff;
         yh         = use_y0 ? s4_yh0_ff : s4_yh1_ff;
         rd_addr[b] = AW'(yh) * AW'(HALF_W) + AW'(xh);
         bank_ok[b] = (use_x0 ? s4_vx0_ff : s4_vx1_ff) & (use_y0 ? s4_vy0_ff : s4_vy1_ff);
         wr_en[b]   = load_ok && (load_bank == 2'(b));
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      abwn_ram #(
         .WIDTH (PIX_BITS),
         .DEPTH (RAM_D)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (load_addr),
         .wr_data (s4_pix_ff),
         .rd_en   (rd_en),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   // stage 5: pad and place neighbours, push
   logic         s5_ok_ff [4];
   logic         s5_xpar_ff, s5_ypar_ff;
   logic [F-1:0] s5_fx_ff, s5_fy_ff;
   logic [9:0]   s5_col_ff, s5_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= rd_en;
      end
      for (int b = 0; b < 4; b++) begin
         s5_ok_ff[b] <= bank_ok[b];
      end
      s5_xpar_ff <= s4_xpar_ff;
      s5_ypar_ff <= s4_ypar_ff;
      s5_fx_ff   <= s4_fx_ff;
      s5_fy_ff   <= s4_fy_ff;
      s5_col_ff  <= s4_col_ff;
      s5_row_ff  <= s4_row_ff;
   end

   logic [23:0] bank_pix [4];
   logic [23:0] nb [4];

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         bank_pix[b] = s5_ok_ff[b] ? rd_data[b] : {PAD_VALUE, PAD_VALUE, PAD_VALUE};
      end
      // neighbour k: bit 0 steps x, bit 1 steps y
      for (int k = 0; k < 4; k++) begin
         nb[k] = bank_pix[{s5_ypar_ff ^ k[1], s5_xpar_ff ^ k[0]}];
      end
   end

   assign q_push = s5_valid_ff;
   assign q_data = {s5_col_ff, s5_row_ff, s5_fx_ff, s5_fy_ff, nb[3], nb[2], nb[1], nb[0]};
endmodule

### rtl/core/abwn_back.sv
// Back half: bilinear weights, blend, rounding and normalization to Q1.16.
// Depends on abwn_pkg; drains abwn_queue and drives the result port.
module abwn_back #(
   parameter int FRAC_BITS = 16,
   parameter int ENTRY_W   = 4 * 24 + 2 * 16 + 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  logic [ENTRY_W-1:0]          q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output abwn_pkg::rsp_payload_type   rsp_payload
);
   import abwn_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int WW = 2 * F + 1;
   localparam int PB = WW + 8;
   localparam int AB = PB + 2;

   logic         advance;
   logic         b1_valid_ff, b2_valid_ff, rsp_valid_ff;

   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign q_pop   = advance & q_not_empty;

   // unpack head entry
   logic [23:0]  e_pix [4];
   logic [F-1:0] e_fx, e_fy;
   logic [9:0]   e_col, e_row;
   logic [F:0]   one, gx0, gx1, gy0, gy1;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         e_pix[k] = q_data[24*k +: 24];
      end
      e_fy  = q_data[96 +: F];
      e_fx  = q_data[96 + F +: F];
      e_row = q_data[96 + 2*F +: 10];
      e_col = q_data[106 + 2*F +: 10];
      one   = {1'b1, {F{1'b0}}};
      gx1   = (F+1)'(e_fx);
      gy1   = (F+1)'(e_fy);
      gx0   = one - gx1;
      gy0   = one - gy1;
   end

   // b1: weights
   logic [WW-1:0] w_ff [4];
   logic [23:0]   b1_pix_ff [4];
   logic [9:0]    b1_col_ff, b1_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff <= q_not_empty;
      end
      if (advance) begin
         w_ff[0]   <= WW'(gx0 * gy0);
         w_ff[1]   <= WW'(gx1 * gy0);
         w_ff[2]   <= WW'(gx0 * gy1);
         w_ff[3]   <= WW'(gx1 * gy1);
         b1_pix_ff <= e_pix;
         b1_col_ff <= e_col;
         b1_row_ff <= e_row;
      end
   end

   // b2: weighted channels
   logic [PB-1:0] prod_ff [4][3];
   logic [9:0]    b2_col_ff, b2_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (advance) begin
         b2_valid_ff <= b1_valid_ff;
      end
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[k][c] <= PB'(w_ff[k] * b1_pix_ff[k][8*c +: 8]);
            end
         end
         b2_col_ff <= b1_col_ff;
         b2_row_ff <= b1_row_ff;
      end
   end

   // b3: sum, round half up, saturate to 255, divide by 255 as v*257 plus rounding bit
   logic [AB-1:0] acc [3];
   logic [AB-1:0] vfull [3];
   logic [7:0]    v [3];
   logic [16:0]   norm [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c]   = AB'(prod_ff[0][c]) + AB'(prod_ff[1][c])
                  + AB'(prod_ff[2][c]) + AB'(prod_ff[3][c])
                  + (AB'(1) << (2*F - 1));
         vfull[c] = acc[c] >> (2*F);
         v[c]     = (vfull[c] > AB'(255)) ? 8'd255 : vfull[c][7:0];
         norm[c]  = {1'b0, v[c], v[c]} + 17'(v[c][7]);
      end
   end

   rsp_payload_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b2_valid_ff;
      end
      if (advance) begin
         rsp_payload_ff.red_norm   <= norm[2];
         rsp_payload_ff.green_norm <= norm[1];
         rsp_payload_ff.blue_norm  <= norm[0];
         rsp_payload_ff.out_col    <= b2_col_ff;
         rsp_payload_ff.out_row    <= b2_row_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
endmodule
